/* hdl/psd_pkg.sv */
// Shared types and constants for the point-to-segment distance pipeline.
// No dependencies.
package psd_pkg;

    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned THRESH_W     = 16;
    localparam logic [15:0] THRESH_RESET = 16'd17;
    localparam logic [CFG_ADDR_W-1:0] REG_DEGEN_THRESH = 1'b0;

    // Control word carried between pipeline cells.
    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage

/* hdl/psd_if.sv */
// Valid/ready stream interface used for both channels.
// Depends on nothing; the payload width is a parameter.
interface psd_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/psd_sqrt_cell.sv */
// One cell of the pipelined integer square root: one result bit per cell.
// Depends on psd_pkg.
module psd_sqrt_cell #(
    parameter int unsigned SW = 64,
    parameter int unsigned RW = 32,
    parameter int unsigned K  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  psd_pkg::t_ctl         i_ctl,
    input  logic [SW-1:0]         i_rem,
    input  logic [RW-1:0]         i_root,
    output psd_pkg::t_ctl         o_ctl,
    output logic [SW-1:0]         o_rem,
    output logic [RW-1:0]         o_root
);
    import psd_pkg::*;

    t_ctl          r_ctl;
    logic [SW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [SW+1:0] w_trial;
    logic [RW-1:0] w_cand;

    // Candidate root with bit K set. The remainder holds x - root^2, so the
    // candidate fits when the remainder covers 2*root*2^K + 2^(2K).
    always_comb begin
        w_cand  = i_root | (RW'(1) << K);
        w_trial = ((SW+2)'(i_root) << (K+1)) + ((SW+2)'(1) << (2*K));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            if ({2'b00, i_rem} >= w_trial) begin
                r_rem  <= SW'({2'b00, i_rem} - w_trial);
                r_root <= w_cand;
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

/* hdl/psd_div_cell.sv */
// One cell of the restoring divider that forms the projection parameter t.
// Depends on psd_pkg; carries the geometry alongside the partial quotient.
module psd_div_cell #(
    parameter int unsigned LW = 64,
    parameter int unsigned TW = 17,
    parameter int unsigned PW = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  psd_pkg::t_ctl i_ctl,
    input  logic [LW:0]   i_rem,
    input  logic [LW-1:0] i_len,
    input  logic [TW-1:0] i_t,
    input  logic [PW-1:0] i_pay,
    output psd_pkg::t_ctl o_ctl,
    output logic [LW:0]   o_rem,
    output logic [LW-1:0] o_len,
    output logic [TW-1:0] o_t,
    output logic [PW-1:0] o_pay
);
    import psd_pkg::*;

    t_ctl          r_ctl;
    logic [LW:0]   r_rem;
    logic [LW-1:0] r_len;
    logic [TW-1:0] r_t;
    logic [PW-1:0] r_pay;
    logic [LW+1:0] w_sh;
    logic          w_ge;

    assign w_sh = {i_rem, 1'b0};
    assign w_ge = w_sh >= {2'b00, i_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_rem <= w_ge ? (LW+1)'(w_sh - {2'b00, i_len}) : (LW+1)'(w_sh);
            r_t   <= {i_t[TW-2:0], w_ge};
            r_len <= i_len;
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_len = r_len;
    assign o_t   = r_t;
    assign o_pay = r_pay;
endmodule

/* hdl/point_segment_distance.sv */
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg, psd_if, psd_div_cell and psd_sqrt_cell.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------
//  i_query | in  | point, segment start, segment end (x,y,z) | valid/ready
//  o_res   | out | distance, degenerate                      | valid/ready
//  apb     | in  | degenerate_threshold at byte address 0    | psel/penable
//
// One transaction per cycle is accepted unless the pipeline stalls. The
// pipeline has 4 setup stages, T_FRAC_BITS divider cells, 4 offset stages,
// COORD_WIDTH+3 square-root cells and the output register; the divider and
// square-root cell chains make up most of the pipeline.
// The whole pipeline advances together and stalls only when the output
// register holds a result that is not taken. Synchronous active-low reset
// clears the valid bits and sets the threshold to 17.
module point_segment_distance #(
    parameter int unsigned COORD_WIDTH = 24,
    parameter int unsigned FRAC_BITS   = 12,
    parameter int unsigned T_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psd_if.sink          i_query,
    psd_if.source        o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [psd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [psd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [psd_pkg::CFG_DATA_W-1:0] prdata,
    output logic         pready
);
    import psd_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned DW = CW + 1;           // difference width
    localparam int unsigned MW = 2 * DW;           // product width
    localparam int unsigned SW = MW + 2;           // sum of three products
    localparam int unsigned TW = T_FRAC_BITS + 1;
    localparam int unsigned OW = DW + TW;          // t * |se|
    localparam int unsigned RW = SW / 2 + 1;       // root width
    localparam int unsigned OUT_W = CW + 1;
    localparam int unsigned PW = 6 * DW;           // sp and se carried along

    // FRAC_BITS only sets the meaning of the fixed-point numbers; the
    // datapath is the same for any split between integer and fraction bits.

    // ---------------- configuration register ----------------
    logic [THRESH_W-1:0] r_thresh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && paddr == REG_DEGEN_THRESH) begin
            r_thresh <= pwdata[THRESH_W-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_DEGEN_THRESH) ? CFG_DATA_W'(r_thresh) : '0;

    // ---------------- global advance ----------------
    logic w_adv;
    logic r_out_valid;
    assign w_adv         = !r_out_valid || o_res.ready;
    assign i_query.ready = w_adv;

    // ---------------- stage 1: differences ----------------
    t_ctl                   r1_ctl;
    logic signed [DW-1:0]   r1_sp [3];
    logic signed [DW-1:0]   r1_se [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (w_adv) begin
            r1_ctl <= '{valid: i_query.valid, degen: 1'b0};
        end
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r1_sp[a] <= DW'($signed(i_query.data[a*CW +: CW]))
                          - DW'($signed(i_query.data[(3+a)*CW +: CW]));
                r1_se[a] <= DW'($signed(i_query.data[(6+a)*CW +: CW]))
                          - DW'($signed(i_query.data[(3+a)*CW +: CW]));
            end
        end
    end

    // ---------------- stage 2: products ----------------
    t_ctl                  r2_ctl;
    logic signed [DW-1:0]  r2_sp [3];
    logic signed [DW-1:0]  r2_se [3];
    logic signed [MW-1:0]  r2_ee [3];
    logic signed [MW-1:0]  r2_pe [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (w_adv) begin
            r2_ctl <= r1_ctl;
        end
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r2_sp[a] <= r1_sp[a];
                r2_se[a] <= r1_se[a];
                r2_ee[a] <= MW'(r1_se[a]) * MW'(r1_se[a]);
                r2_pe[a] <= MW'(r1_sp[a]) * MW'(r1_se[a]);
            end
        end
    end

    // ---------------- stage 3: sums and decisions ----------------
    t_ctl                  r3_ctl;
    logic signed [DW-1:0]  r3_sp [3];
    logic signed [DW-1:0]  r3_se [3];
    logic        [SW-1:0]  r3_len;
    logic signed [SW-1:0]  r3_dot;
    logic        [SW-1:0]  w_len;
    logic signed [SW-1:0]  w_dot;
    assign w_len = SW'(unsigned'(r2_ee[0])) + SW'(unsigned'(r2_ee[1]))
                 + SW'(unsigned'(r2_ee[2]));
    assign w_dot = SW'(r2_pe[0]) + SW'(r2_pe[1]) + SW'(r2_pe[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (w_adv) begin
            r3_ctl <= '{valid: r2_ctl.valid, degen: w_len < SW'(r_thresh)};
        end
        if (w_adv) begin
            r3_sp  <= r2_sp;
            r3_se  <= r2_se;
            r3_len <= w_len;
            r3_dot <= w_dot;
        end
    end

    // ---------------- stage 4: clamp, seed divider ----------------
    // Payload carried through the divider: sp and se vectors.
    // When t is clamped the divider is seeded so every cell produces the
    // clamped bits: zero remainder yields 0, and for t = 1 the flag below
    // forces the result. A degenerate segment always takes t = 0.
    t_ctl            r4_ctl;
    logic [SW:0]     r4_rem;
    logic [SW-1:0]   r4_len;
    logic [PW-1:0]   r4_pay;
    logic            r4_one;
    logic [PW-1:0]   w_pay;
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_pay[a*DW +: DW]     = r3_sp[a];
            w_pay[(3+a)*DW +: DW] = r3_se[a];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (w_adv) begin
            r4_ctl <= r3_ctl;
        end
        if (w_adv) begin
            r4_pay <= w_pay;
            r4_len <= (r3_len == '0) ? SW'(1) : r3_len;
            r4_one <= !r3_dot[SW-1] && r3_dot != '0 && !r3_ctl.degen
                      && unsigned'(r3_dot) >= r3_len;
            if (r3_dot[SW-1] || r3_dot == '0 || r3_ctl.degen
                || unsigned'(r3_dot) >= r3_len) begin
                r4_rem <= '0;
            end else begin
                r4_rem <= (SW+1)'(unsigned'(r3_dot));
            end
        end
    end

    // ---------------- divider chain ----------------
    t_ctl          dv_ctl [T_FRAC_BITS+1];
    logic [SW:0]   dv_rem [T_FRAC_BITS+1];
    logic [SW-1:0] dv_len [T_FRAC_BITS+1];
    logic [TW-1:0] dv_t   [T_FRAC_BITS+1];
    logic [PW+1:0] dv_pay [T_FRAC_BITS+1];
    assign dv_ctl[0] = r4_ctl;
    assign dv_rem[0] = r4_rem;
    assign dv_len[0] = r4_len;
    assign dv_t[0]   = '0;
    assign dv_pay[0] = {r4_one, r4_ctl.degen, r4_pay};
    for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_div
        psd_div_cell #(.LW(SW), .TW(TW), .PW(PW+2)) u_cell (
            .i_clk, .i_rst_n, .i_en(w_adv),
            .i_ctl(dv_ctl[k]), .i_rem(dv_rem[k]), .i_len(dv_len[k]),
            .i_t(dv_t[k]), .i_pay(dv_pay[k]),
            .o_ctl(dv_ctl[k+1]), .o_rem(dv_rem[k+1]), .o_len(dv_len[k+1]),
            .o_t(dv_t[k+1]), .o_pay(dv_pay[k+1])
        );
    end

    // ---------------- offset stages ----------------
    logic [TW-1:0]         w_t;
    logic [PW-1:0]         w_dpay;
    assign w_dpay = dv_pay[T_FRAC_BITS][PW-1:0];
    assign w_t    = dv_pay[T_FRAC_BITS][PW+1] ? (TW'(1) << T_FRAC_BITS)
                                              : dv_t[T_FRAC_BITS];

    t_ctl                 r5_ctl;
    logic signed [DW-1:0] r5_sp [3];
    logic                 r5_neg [3];
    logic [OW-1:0]        r5_sc [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (w_adv) begin
            r5_ctl <= dv_ctl[T_FRAC_BITS];
        end
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                logic signed [DW-1:0] se;
                se = w_dpay[(3+a)*DW +: DW];
                r5_sp[a]  <= w_dpay[a*DW +: DW];
                r5_neg[a] <= se[DW-1];
                r5_sc[a]  <= OW'(w_t) * OW'(se[DW-1] ? -se : se);
            end
        end
    end

    // diff = sp - off, off = floor(t*se / 2^T)
    t_ctl                   r6_ctl;
    logic signed [DW+1:0]   r6_df [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl <= '0;
        end else if (w_adv) begin
            r6_ctl <= r5_ctl;
        end
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                logic [OW:0] up;
                up = r5_neg[a] ? ((OW+1)'(r5_sc[a]) + (OW+1)'((1 << T_FRAC_BITS) - 1))
                               : (OW+1)'(r5_sc[a]);
                if (r5_neg[a])
                    r6_df[a] <= (DW+2)'(r5_sp[a]) + (DW+2)'(up >> T_FRAC_BITS);
                else
                    r6_df[a] <= (DW+2)'(r5_sp[a]) - (DW+2)'(up >> T_FRAC_BITS);
            end
        end
    end

    // squares
    t_ctl                 r7_ctl;
    logic [2*DW+3:0]      r7_sq [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_ctl <= '0;
        end else if (w_adv) begin
            r7_ctl <= r6_ctl;
        end
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                logic [DW+1:0] m;
                m = r6_df[a][DW+1] ? (DW+2)'(0) - unsigned'(r6_df[a])
                                   : unsigned'(r6_df[a]);
                r7_sq[a] <= (2*DW+4)'(m) * (2*DW+4)'(m);
            end
        end
    end

    // Sum of squares. The degenerate path needs no separate sum: it forces
    // t = 0 above, so the difference equals sp.
    t_ctl            r8_ctl;
    logic [SW-1:0]   r8_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_ctl <= '0;
        end else if (w_adv) begin
            r8_ctl <= r7_ctl;
        end
        if (w_adv) begin
            r8_sum <= SW'(r7_sq[0]) + SW'(r7_sq[1]) + SW'(r7_sq[2]);
        end
    end

    // The degenerate flag rides in the divider payload.
    logic r_dg5, r_dg6, r_dg7, r_dg8;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dg5 <= dv_pay[T_FRAC_BITS][PW];
            r_dg6 <= r_dg5;
            r_dg7 <= r_dg6;
            r_dg8 <= r_dg7;
        end
    end

    // ---------------- square-root chain ----------------
    t_ctl          sq_ctl  [RW+1];
    logic [SW-1:0] sq_rem  [RW+1];
    logic [RW-1:0] sq_root [RW+1];
    assign sq_ctl[0]  = '{valid: r8_ctl.valid, degen: r_dg8};
    assign sq_rem[0]  = r8_sum;
    assign sq_root[0] = '0;
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        psd_sqrt_cell #(.SW(SW), .RW(RW), .K(RW-1-k)) u_cell (
            .i_clk, .i_rst_n, .i_en(w_adv),
            .i_ctl(sq_ctl[k]), .i_rem(sq_rem[k]), .i_root(sq_root[k]),
            .o_ctl(sq_ctl[k+1]), .o_rem(sq_rem[k+1]), .o_root(sq_root[k+1])
        );
    end

    // ---------------- output register ----------------
    logic [OUT_W-1:0] r_dist;
    logic             r_degen;
    logic [RW-1:0]    w_root;
    assign w_root = sq_root[RW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= sq_ctl[RW].valid;
        end
        if (w_adv) begin
            r_dist  <= (w_root > RW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                    : OUT_W'(w_root);
            r_degen <= sq_ctl[RW].degen;
        end
    end
    assign o_res.valid = r_out_valid;
    assign o_res.data  = {r_degen, r_dist};

`ifndef SYNTH
    // A held result must not change while the consumer stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))
        else $error("result changed under stall");
    // The input side is ready whenever the output register is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_query.ready)
        else $error("input blocked with empty output");
    // A degenerate segment is never clamped to t = 1.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_ctl.valid && r4_one |-> !r4_ctl.degen)
        else $error("degenerate segment clamped to the end");
`endif
endmodule
